/* design/pcd_pkg.sv */
package pcd_pkg;

    localparam int LEVEL_BITS      = 8;
    localparam int GAMMA_FRAC_BITS = 16;

    localparam int LEVEL_W   = 8;
    localparam int HALF_W    = 16;
    localparam int PULSE_W   = 10;
    localparam int GAMMA_W   = GAMMA_FRAC_BITS + 1;
    localparam int ROM_DEPTH = 2 ** LEVEL_W;

    localparam int unsigned LVL_MAX = (2 ** LEVEL_BITS) - 1;
    localparam logic [63:0] G_ONE   = 64'd1 << GAMMA_FRAC_BITS;

    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_SET_LEVEL = 2'd1;
    localparam logic [1:0] OP_SWITCH    = 2'd2;

    localparam logic [1:0] CH_BOTH   = 2'd0;
    localparam logic [1:0] CH_FIRST  = 2'd1;
    localparam logic [1:0] CH_SECOND = 2'd2;

    localparam logic [2:0] CFG_HALF_CYCLE  = 3'd0;
    localparam logic [2:0] CFG_PULSE_WIDTH = 3'd1;
    localparam logic [2:0] CFG_RESTORE     = 3'd2;
    localparam logic [2:0] CFG_MIN_APPLY   = 3'd3;
    localparam logic [2:0] CFG_MAX_CLAMP   = 3'd4;

    localparam logic [HALF_W-1:0]  HALF_CYCLE_RST  = 16'd9000;
    localparam logic [PULSE_W-1:0] PULSE_WIDTH_RST = 10'd50;
    localparam logic [LEVEL_W-1:0] RESTORE_RST     = 8'd128;
    localparam logic [LEVEL_W-1:0] MIN_APPLY_RST   = 8'd13;
    localparam logic [LEVEL_W-1:0] MAX_CLAMP_RST   = 8'd204;
    localparam logic [LEVEL_W-1:0] LAST_LEVEL_RST  = 8'd128;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         channel;
        logic [LEVEL_W-1:0] level;
        logic               switch_on;
        logic               zero_cross;
    } pcd_in_t;

    typedef struct packed {
        logic               gate_one;
        logic               gate_two;
        logic [LEVEL_W-1:0] led_duty_one;
        logic [LEVEL_W-1:0] led_duty_two;
        logic               idle_one;
        logic               idle_two;
    } pcd_out_t;

    typedef struct packed {
        logic [HALF_W-1:0]  half_cycle;
        logic [PULSE_W-1:0] pulse_width;
        logic [LEVEL_W-1:0] restore_level;
        logic [LEVEL_W-1:0] min_apply;
        logic [LEVEL_W-1:0] max_clamp;
    } pcd_cfg_t;

    // per-channel request decoded from one input item
    typedef struct packed {
        logic               tick;
        logic               zero_cross;
        logic               set_level;
        logic               switch_on;
        logic               switch_off;
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] applied;
        logic [HALF_W-1:0]  fire_delay;
    } pcd_cmd_t;

    typedef struct packed {
        logic               gate;
        logic [LEVEL_W-1:0] led_duty;
        logic               stopped;
    } pcd_stat_t;

    typedef logic [GAMMA_W-1:0] gamma_t;
    typedef gamma_t [ROM_DEPTH-1:0] gamma_rom_t;

    function automatic logic [63:0] pow5_fx(logic [63:0] t);
        logic [63:0] p;
        p = t;
        for (int i = 0; i < 4; i++)
            p = (p * t) >> GAMMA_FRAC_BITS;
        return p;
    endfunction

    function automatic gamma_t gamma_of(int unsigned lvl);
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] c;
        logic [63:0] g;
        int unsigned lv;
        lv = (lvl > LVL_MAX) ? LVL_MAX : lvl;
        a = (64'(lv) << GAMMA_FRAC_BITS) / LVL_MAX;
        s = (a * a) >> GAMMA_FRAC_BITS;
        t = 64'd0;
        // bitwise search for the fifth root of a
        for (int b = GAMMA_FRAC_BITS; b >= 0; b--) begin
            c = t | (64'd1 << b);
            if (c <= G_ONE && pow5_fx(c) <= a)
                t = c;
        end
        g = (s * t) >> GAMMA_FRAC_BITS;
        if (g > G_ONE)
            g = G_ONE;
        return GAMMA_W'(g);
    endfunction

    function automatic gamma_rom_t gamma_rom_init();
        gamma_rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++)
            rom[i] = gamma_of(i);
        return rom;
    endfunction

    localparam gamma_rom_t GAMMA_ROM = gamma_rom_init();

endpackage

/* design/pcd_delay.sv */
module pcd_delay import pcd_pkg::*;
(
    input  pcd_cfg_t           cfg,
    input  logic [1:0]         op,
    input  logic [LEVEL_W-1:0] level,
    output logic [LEVEL_W-1:0] applied,
    output logic [HALF_W-1:0]  fire_delay
);

    logic [LEVEL_W-1:0]        raw_level;
    logic [LEVEL_W-1:0]        clamp_level;
    gamma_t                    gamma;
    logic [GAMMA_W-1:0]        inv_gamma;
    logic [HALF_W+GAMMA_W-1:0] product;

    always_comb
    begin
        // a switch request carrying a level of zero uses the restore level
        raw_level   = (op == OP_SWITCH && level == '0) ? cfg.restore_level : level;
        applied     = (raw_level < cfg.min_apply) ? cfg.min_apply : raw_level;
        clamp_level = (applied > cfg.max_clamp) ? cfg.max_clamp : applied;
        gamma       = GAMMA_ROM[clamp_level];
        inv_gamma   = GAMMA_W'(G_ONE) - gamma;
        product     = {{GAMMA_W{1'b0}}, cfg.half_cycle} * {{HALF_W{1'b0}}, inv_gamma};
        fire_delay  = product[GAMMA_FRAC_BITS +: HALF_W];
    end

endmodule

/* design/pcd_channel.sv */
module pcd_channel import pcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  pcd_cmd_t           cmd,
    input  logic [PULSE_W-1:0] pulse_width,
    output pcd_stat_t          stat
);

    logic               stopped_reg, stopped_next;
    logic [HALF_W-1:0]  fire_delay_reg, fire_delay_next;
    logic [HALF_W-1:0]  delay_count_reg, delay_count_next;
    logic               armed_reg, armed_next;
    logic [PULSE_W-1:0] pulse_count_reg, pulse_count_next;
    logic               gate_reg, gate_next;
    logic [LEVEL_W-1:0] last_level_reg, last_level_next;
    logic               was_off_reg, was_off_next;
    logic               sw_on_reg, sw_on_next;
    logic [LEVEL_W-1:0] led_reg, led_next;
    logic               do_apply;
    logic               do_stop;

    always_comb
    begin
        stopped_next     = stopped_reg;
        fire_delay_next  = fire_delay_reg;
        delay_count_next = delay_count_reg;
        armed_next       = armed_reg;
        pulse_count_next = pulse_count_reg;
        gate_next        = gate_reg;
        last_level_next  = last_level_reg;
        was_off_next     = was_off_reg;
        sw_on_next       = sw_on_reg;
        led_next         = led_reg;
        do_apply         = 1'b0;
        do_stop          = 1'b0;

        if (cmd.tick)
        begin
            if (gate_next)
            begin
                if (pulse_count_next <= PULSE_W'(1))
                begin
                    gate_next        = 1'b0;
                    pulse_count_next = '0;
                end
                else
                    pulse_count_next = pulse_count_next - PULSE_W'(1);
            end
            if (armed_next)
            begin
                if (delay_count_next <= HALF_W'(1))
                begin
                    gate_next        = 1'b1;
                    pulse_count_next = pulse_width;
                    armed_next       = 1'b0;
                    delay_count_next = '0;
                end
                else
                    delay_count_next = delay_count_next - HALF_W'(1);
            end
            if (cmd.zero_cross && !stopped_reg)
            begin
                if (fire_delay_reg == '0)
                begin
                    gate_next        = 1'b1;
                    pulse_count_next = pulse_width;
                    armed_next       = 1'b0;
                    delay_count_next = '0;
                end
                else
                begin
                    delay_count_next = fire_delay_reg;
                    armed_next       = 1'b1;
                end
            end
        end

        if (cmd.set_level)
        begin
            last_level_next = cmd.level;
            if (cmd.level == '0)
            begin
                do_stop  = 1'b1;
                led_next = '0;
            end
            else
                do_apply = 1'b1;
        end

        if (cmd.switch_on)
        begin
            sw_on_next = 1'b1;
            if (last_level_reg != cmd.level || was_off_reg)
            begin
                last_level_next = cmd.level;
                was_off_next    = 1'b0;
                do_apply        = 1'b1;
            end
        end

        if (cmd.switch_off)
        begin
            sw_on_next   = 1'b0;
            was_off_next = 1'b1;
            do_stop      = 1'b1;
            led_next     = '0;
        end

        if (do_apply)
        begin
            led_next = cmd.applied;
            if (sw_on_next)
            begin
                stopped_next    = 1'b0;
                fire_delay_next = cmd.fire_delay;
            end
            else
                do_stop = 1'b1;
        end

        if (do_stop)
        begin
            stopped_next     = 1'b1;
            armed_next       = 1'b0;
            delay_count_next = '0;
            gate_next        = 1'b0;
            pulse_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg     <= 1'b1;
            fire_delay_reg  <= HALF_CYCLE_RST;
            delay_count_reg <= '0;
            armed_reg       <= 1'b0;
            pulse_count_reg <= '0;
            gate_reg        <= 1'b0;
            last_level_reg  <= LAST_LEVEL_RST;
            was_off_reg     <= 1'b0;
            sw_on_reg       <= 1'b0;
            led_reg         <= '0;
        end
        else if (en)
        begin
            stopped_reg     <= stopped_next;
            fire_delay_reg  <= fire_delay_next;
            delay_count_reg <= delay_count_next;
            armed_reg       <= armed_next;
            pulse_count_reg <= pulse_count_next;
            gate_reg        <= gate_next;
            last_level_reg  <= last_level_next;
            was_off_reg     <= was_off_next;
            sw_on_reg       <= sw_on_next;
            led_reg         <= led_next;
        end
    end

    assign stat.gate     = gate_reg;
    assign stat.led_duty = led_reg;
    assign stat.stopped  = stopped_reg;

endmodule

/* design/phase_cut_triac_dimmer.sv */
// Two-channel phase-cut triac dimmer. Each request is a one-microsecond tick
// (optionally marking a zero cross) or a brightness / on-off command for one or
// both channels; every request yields exactly one result showing both gates,
// LED duties and idle flags after that request. A request is held in the input
// register, and the channel state, which doubles as the result register, updates
// from it through the gamma ROM and the 16x17 delay multiply; one request is
// taken every cycle while the result side is not stalled by out_ready.
// Configuration writes are applied immediately and should be made only while
// no request is in flight. No clearing pass after reset.
module phase_cut_triac_dimmer import pcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pcd_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pcd_out_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic               in_valid_reg;
    pcd_in_t            in_data_reg;
    logic               out_valid_reg, out_valid_next;
    pcd_cfg_t           cfg_reg;
    logic               advance;
    logic               sel_one;
    logic               sel_two;
    logic [LEVEL_W-1:0] applied;
    logic [HALF_W-1:0]  fire_delay;
    pcd_cmd_t           cmd_one;
    pcd_cmd_t           cmd_two;
    pcd_stat_t          stat_one;
    pcd_stat_t          stat_two;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_cycle    <= HALF_CYCLE_RST;
            cfg_reg.pulse_width   <= PULSE_WIDTH_RST;
            cfg_reg.restore_level <= RESTORE_RST;
            cfg_reg.min_apply     <= MIN_APPLY_RST;
            cfg_reg.max_clamp     <= MAX_CLAMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_CYCLE:  cfg_reg.half_cycle    <= cfg_data;
                CFG_PULSE_WIDTH: cfg_reg.pulse_width   <= cfg_data[PULSE_W-1:0];
                CFG_RESTORE:     cfg_reg.restore_level <= cfg_data[LEVEL_W-1:0];
                CFG_MIN_APPLY:   cfg_reg.min_apply     <= cfg_data[LEVEL_W-1:0];
                CFG_MAX_CLAMP:   cfg_reg.max_clamp     <= cfg_data[LEVEL_W-1:0];
                default:         ;
            endcase
        end
    end

    pcd_delay u_delay
    (
        .cfg        (cfg_reg),
        .op         (in_data_reg.op),
        .level      (in_data_reg.level),
        .applied    (applied),
        .fire_delay (fire_delay)
    );

    // channel code 3 selects nothing
    assign sel_one = (in_data_reg.channel == CH_BOTH) || (in_data_reg.channel == CH_FIRST);
    assign sel_two = (in_data_reg.channel == CH_BOTH) || (in_data_reg.channel == CH_SECOND);

    always_comb
    begin
        cmd_one.tick       = (in_data_reg.op == OP_TICK);
        cmd_one.zero_cross = in_data_reg.zero_cross;
        cmd_one.set_level  = (in_data_reg.op == OP_SET_LEVEL) && sel_one;
        cmd_one.switch_on  = (in_data_reg.op == OP_SWITCH) && sel_one && in_data_reg.switch_on;
        cmd_one.switch_off = (in_data_reg.op == OP_SWITCH) && sel_one && !in_data_reg.switch_on;
        cmd_one.level      = in_data_reg.level;
        cmd_one.applied    = applied;
        cmd_one.fire_delay = fire_delay;

        cmd_two            = cmd_one;
        cmd_two.set_level  = (in_data_reg.op == OP_SET_LEVEL) && sel_two;
        cmd_two.switch_on  = (in_data_reg.op == OP_SWITCH) && sel_two && in_data_reg.switch_on;
        cmd_two.switch_off = (in_data_reg.op == OP_SWITCH) && sel_two && !in_data_reg.switch_on;
    end

    pcd_channel u_chan_one
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .cmd         (cmd_one),
        .pulse_width (cfg_reg.pulse_width),
        .stat        (stat_one)
    );

    pcd_channel u_chan_two
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .cmd         (cmd_two),
        .pulse_width (cfg_reg.pulse_width),
        .stat        (stat_two)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid             = out_valid_reg;
    assign out_data.gate_one     = stat_one.gate;
    assign out_data.gate_two     = stat_two.gate;
    assign out_data.led_duty_one = stat_one.led_duty;
    assign out_data.led_duty_two = stat_two.led_duty;
    assign out_data.idle_one     = stat_one.stopped;
    assign out_data.idle_two     = stat_two.stopped;

endmodule

/* design/pcd_checker.sv */
module pcd_checker import pcd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input pcd_out_t out_data
);

    // a stopped channel never drives its gate
    a_idle_gate_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.idle_one |-> !out_data.gate_one)
        else $error("gate one high while idle");

    a_idle_gate_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.idle_two |-> !out_data.gate_two)
        else $error("gate two high while idle");

    // with the result side empty the input side cannot stall
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind phase_cut_triac_dimmer pcd_checker u_checker (.*);
